>>> design/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> design/sct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sct_pkg;

    localparam int TERM_COUNT_DEF = 9;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int FRAC      = 56;
    localparam int MAG_W     = 64;
    localparam int DIGIT_W   = 4;
    localparam int DIG_STEPS = MAG_W / DIGIT_W;

    localparam logic signed [MAG_W-1:0] PI_FX     = 64'sh0324_3F6A_8885_A309;
    localparam logic signed [MAG_W-1:0] NEG_PI_FX = -PI_FX;
    localparam logic signed [MAG_W-1:0] TWO_PI_FX = PI_FX <<< 1;
    localparam logic signed [MAG_W-1:0] ONE_FX    = 64'sd1 <<< FRAC;

    // one request in flight; terms are kept as sign and magnitude
    typedef struct packed {
        logic                    valid;
        logic                    is_cos;
        logic                    neg;
        logic [MAG_W-1:0]        mag;
        logic [MAG_W-1:0]        x2;
        logic signed [MAG_W-1:0] sum;
    } sct_item_t;

endpackage

`default_nettype wire

>>> design/sct_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module sct_mul
(
    input  logic                      clk,
    input  logic                      en,
    input  logic [sct_pkg::MAG_W-1:0] a,
    input  logic [sct_pkg::MAG_W-1:0] b,
    output logic [sct_pkg::MAG_W-1:0] p
);
    import sct_pkg::*;

    localparam int HW = MAG_W / 2;
    localparam int PW = 2 * MAG_W;
    localparam logic [PW-1:0] HALF = PW'(1) << (FRAC - 1);

    logic [MAG_W-1:0] ll_reg;
    logic [MAG_W-1:0] lh_reg;
    logic [MAG_W-1:0] hl_reg;
    logic [MAG_W-1:0] hh_reg;
    logic [MAG_W-1:0] p_reg;
    logic [PW-1:0]    full_next;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg <= MAG_W'(a[HW-1:0]) * MAG_W'(b[HW-1:0]);
            lh_reg <= MAG_W'(a[HW-1:0]) * MAG_W'(b[MAG_W-1:HW]);
            hl_reg <= MAG_W'(a[MAG_W-1:HW]) * MAG_W'(b[HW-1:0]);
            hh_reg <= MAG_W'(a[MAG_W-1:HW]) * MAG_W'(b[MAG_W-1:HW]);
        end
    end

    // partial products summed with the rounding half
    always_comb
    begin
        full_next = PW'(ll_reg) + (PW'(lh_reg) << HW) + (PW'(hl_reg) << HW)
                  + (PW'(hh_reg) << MAG_W) + HALF;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= full_next[FRAC +: MAG_W];
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

>>> design/sct_front.sv
`timescale 1ns / 1ps
`default_nettype none

module sct_front
#(
    parameter int DATA_WIDTH = sct_pkg::DATA_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   req_valid,
    input  logic                   req_type,
    input  logic [DATA_WIDTH-1:0]  angle,
    output sct_pkg::sct_item_t     dout
);
    import sct_pkg::*;

    localparam int ASH = 60 - DATA_WIDTH;

    logic signed [MAG_W-1:0] a_ext;
    logic signed [MAG_W-1:0] adj;
    logic [MAG_W-1:0]        prod;
    sct_item_t               f1_next;
    sct_item_t               f1_reg;
    sct_item_t               f2_next;
    sct_item_t               f2_reg;
    sct_item_t               side_reg [2];
    sct_item_t               out_next;
    sct_item_t               out_reg;

    // scale to q.56 and fold into [-pi, pi)
    always_comb
    begin
        a_ext = signed'({{(MAG_W - DATA_WIDTH){angle[DATA_WIDTH-1]}}, angle} << ASH);
        if (a_ext < NEG_PI_FX)
        begin
            adj = TWO_PI_FX;
        end
        else if (a_ext >= PI_FX)
        begin
            adj = -TWO_PI_FX;
        end
        else
        begin
            adj = '0;
        end
        f1_next        = '0;
        f1_next.valid  = req_valid;
        f1_next.is_cos = req_type;
        f1_next.sum    = a_ext + adj;
    end

    always_comb
    begin
        f2_next     = f1_reg;
        f2_next.neg = f1_reg.sum[MAG_W-1];
        f2_next.mag = f1_reg.sum[MAG_W-1] ? MAG_W'(-f1_reg.sum) : MAG_W'(f1_reg.sum);
    end

    sct_mul u_mul
    (
        .clk (clk),
        .en  (en),
        .a   (f2_reg.mag),
        .b   (f2_reg.mag),
        .p   (prod)
    );

    // first term: x for sine, one for cosine
    always_comb
    begin
        out_next    = side_reg[1];
        out_next.x2 = prod;
        if (side_reg[1].is_cos)
        begin
            out_next.neg = 1'b0;
            out_next.mag = MAG_W'(ONE_FX);
            out_next.sum = ONE_FX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_reg      <= '0;
            f2_reg      <= '0;
            side_reg[0] <= '0;
            side_reg[1] <= '0;
            out_reg     <= '0;
        end
        else if (en)
        begin
            f1_reg      <= f1_next;
            f2_reg      <= f2_next;
            side_reg[0] <= f2_reg;
            side_reg[1] <= side_reg[0];
            out_reg     <= out_next;
        end
    end

    assign dout = out_reg;

endmodule

`default_nettype wire

>>> design/sct_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module sct_cell
#(
    parameter int N = 1
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  sct_pkg::sct_item_t din,
    output sct_pkg::sct_item_t dout
);
    import sct_pkg::*;

    localparam int DSIN  = (2 * N) * (2 * N + 1);
    localparam int DCOS  = (2 * N - 1) * (2 * N);
    localparam int DMAX  = (DSIN > DCOS) ? DSIN : DCOS;
    localparam int REM_W = $clog2(DMAX);
    localparam int V_W   = REM_W + DIGIT_W;
    localparam logic [MAG_W-1:0] HSIN = MAG_W'(DSIN / 2);
    localparam logic [MAG_W-1:0] HCOS = MAG_W'(DCOS / 2);

    function automatic logic [DIGIT_W-1:0] digit_of(input logic [V_W-1:0] v,
                                                    input logic is_cos);
        logic [DIGIT_W-1:0] dg;
        dg = '0;
        for (int k = 1; k < (1 << DIGIT_W); k++)
        begin
            if (v >= (is_cos ? V_W'(k * DCOS) : V_W'(k * DSIN)))
            begin
                dg = DIGIT_W'(k);
            end
        end
        return dg;
    endfunction

    function automatic logic [V_W-1:0] mult_of(input logic [DIGIT_W-1:0] dg,
                                               input logic is_cos);
        return V_W'(dg) * (is_cos ? V_W'(DCOS) : V_W'(DSIN));
    endfunction

    logic [MAG_W-1:0] prod;
    sct_item_t        side_reg [2];
    sct_item_t        prep_next;
    sct_item_t        prep_reg;
    sct_item_t        div_in   [DIG_STEPS];
    sct_item_t        div_reg  [DIG_STEPS];
    logic [REM_W-1:0] rem_in   [DIG_STEPS];
    logic [REM_W-1:0] rem_reg  [DIG_STEPS-1];
    sct_item_t        acc_next;
    sct_item_t        acc_reg;

    sct_mul u_mul
    (
        .clk (clk),
        .en  (en),
        .a   (din.mag),
        .b   (din.x2),
        .p   (prod)
    );

    // rounding half of the divisor
    always_comb
    begin
        prep_next     = side_reg[1];
        prep_next.mag = prod + (side_reg[1].is_cos ? HCOS : HSIN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg[0] <= '0;
            side_reg[1] <= '0;
            prep_reg    <= '0;
        end
        else if (en)
        begin
            side_reg[0] <= din;
            side_reg[1] <= side_reg[0];
            prep_reg    <= prep_next;
        end
    end

    // radix-16 long division by the term divisor, one digit per stage
    for (genvar j = 0; j < DIG_STEPS; j++)
    begin : g_div
        logic [V_W-1:0]     v;
        logic [DIGIT_W-1:0] dg;
        sct_item_t          div_nx;

        if (j == 0)
        begin : g_first
            assign div_in[j] = prep_reg;
            assign rem_in[j] = '0;
        end
        else
        begin : g_next
            assign div_in[j] = div_reg[j-1];
            assign rem_in[j] = rem_reg[j-1];
        end

        always_comb
        begin
            v          = {rem_in[j], div_in[j].mag[MAG_W-1 -: DIGIT_W]};
            dg         = digit_of(v, div_in[j].is_cos);
            div_nx     = div_in[j];
            div_nx.mag = {div_in[j].mag[MAG_W-DIGIT_W-1:0], dg};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                div_reg[j] <= '0;
            end
            else if (en)
            begin
                div_reg[j] <= div_nx;
            end
        end

        if (j < DIG_STEPS - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j] <= REM_W'(v - mult_of(dg, div_in[j].is_cos));
                end
            end
        end
    end

    // new term has the opposite sign of the old one
    always_comb
    begin
        acc_next     = div_reg[DIG_STEPS-1];
        acc_next.neg = ~div_reg[DIG_STEPS-1].neg;
        if (div_reg[DIG_STEPS-1].neg)
        begin
            acc_next.sum = div_reg[DIG_STEPS-1].sum + signed'(div_reg[DIG_STEPS-1].mag);
        end
        else
        begin
            acc_next.sum = div_reg[DIG_STEPS-1].sum - signed'(div_reg[DIG_STEPS-1].mag);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign dout = acc_reg;

endmodule

`default_nettype wire

>>> design/sct_back.sv
`timescale 1ns / 1ps
`default_nettype none

module sct_back
#(
    parameter int DATA_WIDTH = sct_pkg::DATA_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  sct_pkg::sct_item_t           din,
    input  logic                         rsp_ready,
    output logic                         pipe_en,
    output logic                         rsp_valid,
    output logic signed [DATA_WIDTH-1:0] value
);
    import sct_pkg::*;

    localparam int SH = FRAC - (DATA_WIDTH - 2);
    localparam logic [MAG_W-1:0] HALF = MAG_W'(1) << (SH - 1);
    localparam logic [MAG_W-1:0] LIM  = (MAG_W'(1) << (DATA_WIDTH - 1)) - MAG_W'(1);
    localparam logic [MAG_W-1:0] LIMN = MAG_W'(1) << (DATA_WIDTH - 1);

    typedef struct packed {
        logic             valid;
        logic             neg;
        logic [MAG_W-1:0] mag;
    } sct_fin_t;

    sct_fin_t                     b1_next;
    sct_fin_t                     b1_reg;
    sct_fin_t                     b2_next;
    sct_fin_t                     b2_reg;
    logic                         out_load;
    logic                         rsp_valid_reg;
    logic signed [DATA_WIDTH-1:0] value_reg;
    logic signed [DATA_WIDTH-1:0] value_next;

    always_comb
    begin
        b1_next.valid = din.valid;
        b1_next.neg   = din.sum[MAG_W-1];
        b1_next.mag   = din.sum[MAG_W-1] ? MAG_W'(-din.sum) : MAG_W'(din.sum);
    end

    always_comb
    begin
        b2_next     = b1_reg;
        b2_next.mag = (b1_reg.mag + HALF) >> SH;
    end

    // saturate to the output format
    always_comb
    begin
        if (!b2_reg.neg)
        begin
            value_next = (b2_reg.mag > LIM) ? signed'(LIM[DATA_WIDTH-1:0])
                                            : signed'(b2_reg.mag[DATA_WIDTH-1:0]);
        end
        else if (b2_reg.mag > LIMN)
        begin
            value_next = signed'(LIMN[DATA_WIDTH-1:0]);
        end
        else
        begin
            value_next = signed'(DATA_WIDTH'(0) - b2_reg.mag[DATA_WIDTH-1:0]);
        end
    end

    assign out_load = rsp_ready || !rsp_valid_reg;
    assign pipe_en  = out_load || !b2_reg.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_reg <= '0;
            b2_reg <= '0;
        end
        else if (pipe_en)
        begin
            b1_reg <= b1_next;
            b2_reg <= b2_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            rsp_valid_reg <= b2_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            value_reg <= value_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign value     = value_reg;

endmodule

`default_nettype wire

>>> design/sine_cosine_taylor.sv
// sine / cosine by truncated taylor series, fixed point
// request channel: req_valid / req_ready with req_type (0 sine, 1 cosine)
//   and angle, signed q3.(DATA_WIDTH-4) radians
// response channel: rsp_valid / rsp_ready with value, signed q1.(DATA_WIDTH-2),
//   saturated at the format limits
// the angle is folded into [-pi, pi), then a row of TERM_COUNT-1 term cells
//   each multiplies the running term by x^2, divides by its divisor one
//   radix-16 digit per stage and adds the term into the running sum
// each term cell is 20 stages deep (two multiply, one round, sixteen
//   division digits, one accumulate)
// throughput: one request per cycle unless stalled, results in request order
// a stalled response holds value and rsp_valid; the pipe keeps moving until
//   the next result reaches the stage ahead of the output, then req_ready drops
// reset clears all valid flags; no results are pending after reset
`timescale 1ns / 1ps
`default_nettype none

module sine_cosine_taylor
#(
    parameter int TERM_COUNT = sct_pkg::TERM_COUNT_DEF,
    parameter int DATA_WIDTH = sct_pkg::DATA_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  logic                         req_type,
    input  logic signed [DATA_WIDTH-1:0] angle,
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output logic signed [DATA_WIDTH-1:0] value
);
    import sct_pkg::*;

    logic      pipe_en;
    sct_item_t chain [TERM_COUNT];

    sct_front #(.DATA_WIDTH(DATA_WIDTH)) u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .req_valid (req_valid),
        .req_type  (req_type),
        .angle     (angle),
        .dout      (chain[0])
    );

    for (genvar n = 1; n < TERM_COUNT; n++)
    begin : g_cell
        sct_cell #(.N(n)) u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (pipe_en),
            .din   (chain[n-1]),
            .dout  (chain[n])
        );
    end

    sct_back #(.DATA_WIDTH(DATA_WIDTH)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .din       (chain[TERM_COUNT-1]),
        .rsp_ready (rsp_ready),
        .pipe_en   (pipe_en),
        .rsp_valid (rsp_valid),
        .value     (value)
    );

    assign req_ready = pipe_en;

endmodule

`default_nettype wire

>>> design/sct_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sct_checker
#(
    parameter int DATA_WIDTH = sct_pkg::DATA_WIDTH_DEF
)
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic signed [DATA_WIDTH-1:0] value
);
    logic [15:0] outstanding_reg;
    logic [15:0] outstanding_next;

    always_comb
    begin
        outstanding_next = outstanding_reg + 16'(req_valid && req_ready)
                         - 16'(rsp_valid && rsp_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
        end
    end

    // no response without a pending request
    `ASSERT_IMP(a_no_spurious, clk, rst_n, rsp_valid, outstanding_reg != 16'd0)
    // a taken response always frees the pipe for a new request
    `ASSERT_IMP(a_ready_follows, clk, rst_n, rsp_ready, req_ready)
    // an empty response slot never blocks requests
    `ASSERT_IMP(a_empty_takes, clk, rst_n, !rsp_valid, req_ready)
    // stalled response holds
    `ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(value))

endmodule

bind sine_cosine_taylor sct_checker #(.DATA_WIDTH(DATA_WIDTH)) u_sct_checker (.*);

`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int TERMS   = sct_pkg::TERM_COUNT_DEF;
    localparam int W       = sct_pkg::DATA_WIDTH_DEF;
    localparam int LATENCY = 8 + 20 * (TERMS - 1);
    localparam int LIMIT   = 300000;
    localparam int RANDOM_REQS = 1600;
    localparam int PI_Q28  = 843314857;

    localparam logic signed [63:0] HALF_TURN = sct_pkg::PI_FX;
    localparam logic signed [63:0] FULL_TURN = sct_pkg::PI_FX <<< 1;
    localparam logic signed [63:0] UNIT      = 64'sd1 <<< sct_pkg::FRAC;

    typedef enum logic
    {
        OP_SINE   = 1'b0,
        OP_COSINE = 1'b1
    } trig_op_e;

    typedef struct
    {
        logic                drain;
        trig_op_e            op;
        logic signed [W-1:0] ang;
    } trig_req_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_ready;
    logic                req_type  = 1'b0;
    logic signed [W-1:0] angle     = '0;
    logic                rsp_valid;
    logic                rsp_ready = 1'b0;
    logic signed [W-1:0] value;

    trig_req_t           pending[$];
    logic signed [W-1:0] expected_vals[$];
    trig_req_t           next_req;
    logic signed [W-1:0] want_val;
    logic                send_hold;
    int                  send_gap;
    int                  stall_left;
    int                  cycles     = 0;
    int                  errors     = 0;
    int                  sine_reqs  = 0;
    int                  cos_reqs   = 0;
    int                  results    = 0;
    int                  drains     = 0;

    sine_cosine_taylor DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_type  (req_type),
        .angle     (angle),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .value     (value)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
    end

    function automatic logic [63:0] q56_mag(logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic signed [63:0] q56_signed(logic [63:0] m, logic neg);
        return neg ? -$signed(m) : $signed(m);
    endfunction

    // rounded q.56 product, ties away from zero
    function automatic logic signed [63:0] q56_mul(logic signed [63:0] a,
                                                   logic signed [63:0] b);
        logic [127:0] p;
        p = 128'(q56_mag(a)) * 128'(q56_mag(b));
        p = p + (128'd1 << (sct_pkg::FRAC - 1));
        return q56_signed(p[sct_pkg::FRAC +: 64], a[63] ^ b[63]);
    endfunction

    function automatic logic signed [63:0] q56_div(logic signed [63:0] v, logic [63:0] d);
        return q56_signed((q56_mag(v) + d / 2) / d, v[63]);
    endfunction

    function automatic logic signed [W-1:0] taylor_value(trig_op_e op,
                                                         logic signed [W-1:0] ang);
        logic signed [63:0] t;
        logic signed [63:0] x;
        logic signed [63:0] x2;
        logic signed [63:0] term;
        logic signed [63:0] sum;
        logic signed [63:0] r;
        logic signed [63:0] lim_hi;
        logic [63:0]        d;
        int                 sh;
        t = 64'(ang);
        t = (t <<< (60 - W)) + HALF_TURN;
        while (t < 0)
            t = t + FULL_TURN;
        while (t >= FULL_TURN)
            t = t - FULL_TURN;
        x  = t - HALF_TURN;
        x2 = q56_mul(x, x);
        term = (op == OP_COSINE) ? UNIT : x;
        sum  = term;
        for (int n = 1; n < TERMS; n++)
        begin
            d = (op == OP_COSINE) ? 64'((2 * n - 1) * (2 * n)) : 64'((2 * n) * (2 * n + 1));
            term = -q56_div(q56_mul(term, x2), d);
            sum  = sum + term;
        end
        sh = sct_pkg::FRAC - (W - 2);
        r  = q56_signed((q56_mag(sum) + (64'd1 << (sh - 1))) >> sh, sum[63]);
        lim_hi = (64'sd1 <<< (W - 1)) - 1;
        if (r > lim_hi)
            r = lim_hi;
        if (r < -lim_hi - 1)
            r = -lim_hi - 1;
        return r[W-1:0];
    endfunction

    task automatic report_mismatch(string what, logic signed [W-1:0] want,
                                   logic signed [W-1:0] got);
        errors++;
        $display("tb: %s at result %0d: expected %0d, got %0d", what, results, want, got);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_type  <= OP_SINE;
            angle     <= '0;
            send_hold = 1'b0;
            send_gap  = 0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                expected_vals.push_back(taylor_value(trig_op_e'(req_type), angle));
                if (req_type == OP_COSINE)
                    cos_reqs++;
                else
                    sine_reqs++;
                send_hold = 1'b0;
                send_gap  = ((sine_reqs + cos_reqs) % 300 < 60) ? 0 : $urandom_range(0, 9);
            end
            if (!send_hold && send_gap > 0)
            begin
                send_gap--;
            end
            else if (!send_hold && pending.size() > 0)
            begin
                if (pending[0].drain)
                begin
                    // hold off until the pipe is empty
                    if (expected_vals.size() == 0)
                    begin
                        pending.delete(0);
                        drains++;
                    end
                end
                else
                begin
                    next_req = pending.pop_front();
                    req_type <= next_req.op;
                    angle    <= next_req.ang;
                    send_hold = 1'b1;
                end
            end
            req_valid <= send_hold;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_vals.size() == 0)
                begin
                    report_mismatch("unexpected result", '0, value);
                end
                else
                begin
                    want_val = expected_vals.pop_front();
                    if (value !== want_val)
                        report_mismatch("value mismatch", want_val, value);
                end
                results++;
                stall_left = (results % 250 < 50) ? 0 : $urandom_range(0, 9);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= 1'b1;
            end
        end
    end

    function automatic trig_req_t make_req(logic drain, trig_op_e op, int ang);
        trig_req_t r;
        r.drain = drain;
        r.op    = op;
        r.ang   = ang;
        return r;
    endfunction

    initial
    begin
        int edge_angles[$];
        int near_turns[4];
        int a;
        trig_op_e op;
        edge_angles = '{0, 1, -1, 32'h7FFF_FFFF, int'(32'h8000_0000), PI_Q28, -PI_Q28,
                        PI_Q28 - 1, PI_Q28 / 2, -(PI_Q28 / 2), 2 * PI_Q28, -2 * PI_Q28};
        near_turns = '{PI_Q28, -PI_Q28, 2 * PI_Q28, -2 * PI_Q28};

        foreach (edge_angles[i])
        begin
            pending.push_back(make_req(1'b0, OP_SINE, edge_angles[i]));
            pending.push_back(make_req(1'b0, OP_COSINE, edge_angles[i]));
        end
        pending.push_back(make_req(1'b1, OP_SINE, 0));

        for (int i = 0; i < RANDOM_REQS; i++)
        begin
            op = $urandom_range(0, 1) ? OP_COSINE : OP_SINE;
            case ($urandom_range(0, 3))
                1:
                    // around the fold points and whole turns
                    a = near_turns[$urandom_range(0, 3)] + $urandom_range(0, 256) - 128;
                2:
                    begin
                        a = $urandom();
                        a = a >>> $urandom_range(4, 30);
                    end
                default:
                    a = $urandom();
            endcase
            pending.push_back(make_req(1'b0, op, a));
            if (i % 400 == 399)
                pending.push_back(make_req(1'b1, OP_SINE, 0));
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending.size() > 0 || req_valid || expected_vals.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 32) @(posedge clk);

        $display("tb: %0d sine and %0d cosine requests, %0d results checked",
                 sine_reqs, cos_reqs, results);
        $display("tb: %0d drain pauses, %0d mismatches", drains, errors);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        while (cycles < LIMIT)
            @(posedge clk);
        $display("tb: timeout after %0d cycles", cycles);
        $display("tb: failure");
        $finish;
    end

endmodule

>>> files.f
+incdir+design
design/sct_pkg.sv
design/sct_mul.sv
design/sct_front.sv
design/sct_cell.sv
design/sct_back.sv
design/sine_cosine_taylor.sv
design/sct_checker.sv
sim/tb.sv
